// ===== src/assert_macros.svh =====
// Assertion macros used by the ledger engine controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ALTR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ALTR_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ALTR_ASSERT(lbl, clk, rst, prop)
`define ALTR_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== src/altr_pkg.sv =====
// Package with constants, codes and control structs of the ledger engine.
`default_nettype none
package altr_pkg;
   localparam int TABLE_DEPTH = 256;
   localparam int KEY_BITS    = 64;
   localparam int DATA_W      = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int STAT_W      = 3;
   localparam int TYPE_W      = 2;

   localparam logic [TYPE_W-1:0] REQ_ALLOC    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_VALIDATE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TRANSFER = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_QUERY    = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_MISSING = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_LOW     = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_SEQ     = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_FULL    = 3'd4;
   localparam logic [STAT_W-1:0] STATUS_SKIPPED = 3'd5;

   typedef struct packed {
      logic              cap;
      logic              scan_clr;
      logic              scan_run;
      logic              sweep;
      logic              alloc_wr;
      logic              fail_set;
      logic              st_load;
      logic [STAT_W-1:0] st_code;
      logic              q_load;
      logic              snew_load;
      logic              rd_recip;
      logic              wr_send;
      logic              wr_recip;
      logic              vld_clr;
      logic              blk_end;
   } cmd_type;

   typedef struct packed {
      logic              scan_done;
      logic              slot_avail;
      logic              recip_avail;
      logic [STAT_W-1:0] chk_code;
      logic              failed;
      logic              last;
      logic [TYPE_W-1:0] req_kind;
   } sts_type;
endpackage
`default_nettype wire

// ===== src/altr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module altr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== src/altr_dp.sv =====
// Datapath: account tables, key search, balance arithmetic and result registers.
`default_nettype none
module altr_dp import altr_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   input  wire logic [TYPE_W-1:0]   req_type,
   input  wire logic [63:0]         req_account_key,
   input  wire logic [63:0]         req_recipient_key,
   input  wire logic [63:0]         req_amount,
   input  wire logic [63:0]         req_seq_number,
   input  wire logic                req_last_in_block,
   output logic      [STAT_W-1:0]   rsp_status,
   output logic                     rsp_block_done,
   output logic                     rsp_block_accepted,
   output logic      [63:0]         rsp_balance_out,
   output logic      [63:0]         rsp_sequence_out,
   output logic                     rsp_account_found
);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);
   // Each valid store word holds the committed bit and the working bit of one entry.
   localparam int         VLD_COM       = 1;
   localparam int         VLD_WRK       = 0;
   localparam logic [1:0] VLD_NONE      = 2'b00;
   localparam logic [1:0] VLD_BOTH      = 2'b11;
   localparam logic [1:0] VLD_WRK_ONLY  = 2'b01;

   // Captured request.
   logic [TYPE_W-1:0]   kind_ff;
   logic [KEY_BITS-1:0] skey_ff, rkey_ff;
   logic [DATA_W-1:0]   amt_ff, seqn_ff;
   logic                last_ff;

   // Search and sweep control.
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff;
   logic             sfound_ff, sfound_in, rfound_ff, rfound_in, ffound_ff, ffound_in;
   logic [IDX_W-1:0] sidx_ff, sidx_in, ridx_ff, ridx_in, fidx_ff, fidx_in;
   logic             failed_ff, failed_in;

   // Arithmetic holding registers.
   logic [DATA_W-1:0] nbal_ff, nseq_ff, rbase_ff;

   // Result registers.
   logic [STAT_W-1:0] res_status_ff;
   logic              res_done_ff, res_acc_ff, res_found_ff;
   logic [DATA_W-1:0] res_bal_ff, res_seq_ff;

   logic              issue, sweep_wr, look, slot_v, s_hit, r_hit, f_hit;
   logic [IDX_W-1:0]  rd_addr, ridx_eff, tidx;
   logic [KEY_BITS-1:0] key_q;
   logic [1:0]        vld_q;
   logic [DATA_W-1:0] cbal_q, cseq_q, wbal_q, wseq_q, bal_sel, seq_sel, rbase_eff;
   logic [STAT_W-1:0] chk_code;

   logic                key_we, cbal_we, cseq_we, wbal_we, wseq_we, vld_we;
   logic [IDX_W-1:0]    key_wa, cbal_wa, wbal_wa, wseq_wa, vld_wa;
   logic [KEY_BITS-1:0] key_wd;
   logic [DATA_W-1:0]   cbal_wd, cseq_wd, wbal_wd, wseq_wd;
   logic [1:0]          vld_wd;

   assign issue    = cmd.scan_run && (cnt_ff != CNT_END);
   assign sweep_wr = cmd.sweep && pend_ff;
   assign look     = pend_ff && !cmd.sweep && !cmd.vld_clr;
   assign ridx_eff = rfound_ff ? ridx_ff : fidx_ff;
   assign tidx     = sfound_ff ? sidx_ff : fidx_ff;
   assign rd_addr  = issue ? cnt_ff[IDX_W-1:0] : (cmd.rd_recip ? ridx_eff : sidx_ff);

   always_comb begin
      unique case (kind_ff)
         REQ_ALLOC:    slot_v = vld_q[VLD_COM] | vld_q[VLD_WRK];
         REQ_TRANSFER: slot_v = vld_q[VLD_WRK];
         default:      slot_v = vld_q[VLD_COM];
      endcase
   end

   assign s_hit = look && slot_v && (key_q == skey_ff);
   assign r_hit = look && vld_q[VLD_WRK] && (key_q == rkey_ff);
   assign f_hit = look && (vld_q == VLD_NONE);

   // Checks run on the working copy for transfers and on the committed copy otherwise.
   assign bal_sel = (kind_ff == REQ_TRANSFER) ? wbal_q : cbal_q;
   assign seq_sel = (kind_ff == REQ_TRANSFER) ? wseq_q : cseq_q;

   always_comb begin
      if (!sfound_ff) begin
         chk_code = STATUS_MISSING;
      end else if (bal_sel < amt_ff) begin
         chk_code = STATUS_LOW;
      end else if (seqn_ff != seq_sel) begin
         chk_code = STATUS_SEQ;
      end else begin
         chk_code = STATUS_OK;
      end
   end

   // A self transfer credits the already debited balance.
   always_comb begin
      if (rfound_ff && (ridx_ff == sidx_ff)) begin
         rbase_eff = nbal_ff;
      end else if (rfound_ff) begin
         rbase_eff = rbase_ff;
      end else begin
         rbase_eff = '0;
      end
   end

   // Write port selection for each table.
   always_comb begin
      key_we = cmd.alloc_wr || (cmd.wr_recip && !rfound_ff);
      key_wa = cmd.alloc_wr ? tidx : ridx_eff;
      key_wd = cmd.alloc_wr ? skey_ff : rkey_ff;

      cbal_we = cmd.alloc_wr || (sweep_wr && !failed_ff);
      cseq_we = cbal_we;
      cbal_wa = cmd.alloc_wr ? tidx : pidx_ff;
      cbal_wd = cmd.alloc_wr ? amt_ff : wbal_q;
      cseq_wd = cmd.alloc_wr ? '0 : wseq_q;

      wbal_we = cmd.alloc_wr || (sweep_wr && failed_ff) || cmd.wr_send || cmd.wr_recip;
      wseq_we = cmd.alloc_wr || (sweep_wr && failed_ff) || cmd.wr_send
                || (cmd.wr_recip && !rfound_ff);
      if (cmd.alloc_wr) begin
         wbal_wa = tidx;
         wbal_wd = amt_ff;
         wseq_wd = '0;
      end else if (sweep_wr) begin
         wbal_wa = pidx_ff;
         wbal_wd = cbal_q;
         wseq_wd = cseq_q;
      end else if (cmd.wr_send) begin
         wbal_wa = sidx_ff;
         wbal_wd = nbal_ff;
         wseq_wd = nseq_ff;
      end else begin
         wbal_wa = ridx_eff;
         wbal_wd = rbase_eff + amt_ff;
         wseq_wd = '0;
      end
      wseq_wa = wbal_wa;

      // The sweep copies one valid bit of each entry onto the other.
      vld_we = (cmd.vld_clr && issue) || cmd.alloc_wr || sweep_wr
               || (cmd.wr_recip && !rfound_ff);
      if (cmd.vld_clr) begin
         vld_wa = cnt_ff[IDX_W-1:0];
         vld_wd = VLD_NONE;
      end else if (cmd.alloc_wr) begin
         vld_wa = tidx;
         vld_wd = VLD_BOTH;
      end else if (sweep_wr) begin
         vld_wa = pidx_ff;
         vld_wd = failed_ff ? {2{vld_q[VLD_COM]}} : {2{vld_q[VLD_WRK]}};
      end else begin
         vld_wa = ridx_eff;
         vld_wd = VLD_WRK_ONLY;
      end
   end

   altr_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(rd_addr), .rd_data(key_q));
   altr_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_vld_ram (
      .clock(clock), .wr_en(vld_we), .wr_addr(vld_wa), .wr_data(vld_wd),
      .rd_addr(rd_addr), .rd_data(vld_q));
   altr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_cbal_ram (
      .clock(clock), .wr_en(cbal_we), .wr_addr(cbal_wa), .wr_data(cbal_wd),
      .rd_addr(rd_addr), .rd_data(cbal_q));
   altr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_cseq_ram (
      .clock(clock), .wr_en(cseq_we), .wr_addr(cbal_wa), .wr_data(cseq_wd),
      .rd_addr(rd_addr), .rd_data(cseq_q));
   altr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_wbal_ram (
      .clock(clock), .wr_en(wbal_we), .wr_addr(wbal_wa), .wr_data(wbal_wd),
      .rd_addr(rd_addr), .rd_data(wbal_q));
   altr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_wseq_ram (
      .clock(clock), .wr_en(wseq_we), .wr_addr(wseq_wa), .wr_data(wseq_wd),
      .rd_addr(rd_addr), .rd_data(wseq_q));

   // Next state of the control registers.
   always_comb begin
      cnt_in    = cnt_ff;
      pend_in   = issue;
      sfound_in = sfound_ff;
      rfound_in = rfound_ff;
      ffound_in = ffound_ff;
      sidx_in   = sidx_ff;
      ridx_in   = ridx_ff;
      fidx_in   = fidx_ff;
      failed_in = failed_ff;

      if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (s_hit && !sfound_ff) begin
         sfound_in = 1'b1;
         sidx_in   = pidx_ff;
      end
      if (r_hit && !rfound_ff) begin
         rfound_in = 1'b1;
         ridx_in   = pidx_ff;
      end
      if (f_hit && !ffound_ff) begin
         ffound_in = 1'b1;
         fidx_in   = pidx_ff;
      end
      if (cmd.cap) begin
         cnt_in    = '0;
         pend_in   = 1'b0;
         sfound_in = 1'b0;
         rfound_in = 1'b0;
         ffound_in = 1'b0;
      end
      if (cmd.scan_clr) begin
         cnt_in  = '0;
         pend_in = 1'b0;
      end

      if (cmd.fail_set) begin
         failed_in = 1'b1;
      end
      if (cmd.blk_end) begin
         failed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         pend_ff   <= 1'b0;
         sfound_ff <= 1'b0;
         rfound_ff <= 1'b0;
         ffound_ff <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         pend_ff   <= pend_in;
         sfound_ff <= sfound_in;
         rfound_ff <= rfound_in;
         ffound_ff <= ffound_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= cnt_ff[IDX_W-1:0];
      sidx_ff <= sidx_in;
      ridx_ff <= ridx_in;
      fidx_ff <= fidx_in;

      if (cmd.cap) begin
         kind_ff <= req_type;
         skey_ff <= req_account_key[KEY_BITS-1:0];
         rkey_ff <= req_recipient_key[KEY_BITS-1:0];
         amt_ff  <= req_amount;
         seqn_ff <= req_seq_number;
         last_ff <= req_last_in_block;
         res_status_ff <= ((req_type == REQ_TRANSFER) && failed_ff) ? STATUS_SKIPPED
                                                                     : STATUS_OK;
         res_done_ff  <= 1'b0;
         res_acc_ff   <= 1'b0;
         res_bal_ff   <= '0;
         res_seq_ff   <= '0;
         res_found_ff <= 1'b0;
      end
      if (cmd.st_load) begin
         res_status_ff <= cmd.st_code;
      end
      if (cmd.q_load && sfound_ff) begin
         res_bal_ff   <= cbal_q;
         res_seq_ff   <= cseq_q;
         res_found_ff <= 1'b1;
      end
      if (cmd.blk_end) begin
         res_done_ff <= 1'b1;
         res_acc_ff  <= !failed_ff;
      end
      if (cmd.snew_load) begin
         nbal_ff <= wbal_q - amt_ff;
         nseq_ff <= wseq_q + DATA_W'(1);
      end
      if (cmd.wr_send) begin
         rbase_ff <= wbal_q;
      end
   end

   always_comb begin
      sts.scan_done   = (cnt_ff == CNT_END) && !pend_ff;
      sts.slot_avail  = sfound_ff || ffound_ff;
      sts.recip_avail = rfound_ff || ffound_ff;
      sts.chk_code    = chk_code;
      sts.failed      = failed_ff;
      sts.last        = last_ff;
      sts.req_kind    = kind_ff;
   end

   assign rsp_status         = res_status_ff;
   assign rsp_block_done     = res_done_ff;
   assign rsp_block_accepted = res_acc_ff;
   assign rsp_balance_out    = res_bal_ff;
   assign rsp_sequence_out   = res_seq_ff;
   assign rsp_account_found  = res_found_ff;
endmodule
`default_nettype wire

// ===== src/altr_ctrl.sv =====
// Controller state machine that sequences search, update, sweep and response.
`default_nettype none
`include "assert_macros.svh"
module altr_ctrl import altr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [TYPE_W-1:0] req_type,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cmd_type                cmd,
   input  wire sts_type           sts
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_CHK   = 4'd3;
   localparam logic [3:0] S_WRS   = 4'd4;
   localparam logic [3:0] S_WRR   = 4'd5;
   localparam logic [3:0] S_END   = 4'd6;
   localparam logic [3:0] S_SWEEP = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;
   localparam logic [3:0] S_INIT  = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         // After reset every entry of the valid store is cleared, one per cycle.
         S_INIT: begin
            cmd.scan_run = 1'b1;
            cmd.vld_clr  = 1'b1;
            if (sts.scan_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap = 1'b1;
               // Transfers of a failed block skip the search entirely.
               if ((req_type == REQ_TRANSFER) && sts.failed) begin
                  state_in = S_END;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               if (sts.req_kind == REQ_ALLOC) begin
                  if (sts.slot_avail) begin
                     cmd.alloc_wr = 1'b1;
                  end else begin
                     cmd.st_load = 1'b1;
                     cmd.st_code = STATUS_FULL;
                  end
                  state_in = S_RESP;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            unique case (sts.req_kind)
               REQ_VALIDATE: begin
                  cmd.st_load = 1'b1;
                  cmd.st_code = sts.chk_code;
                  state_in    = S_RESP;
               end
               REQ_QUERY: begin
                  cmd.q_load = 1'b1;
                  state_in   = S_RESP;
               end
               default: begin
                  if (sts.chk_code != STATUS_OK) begin
                     cmd.st_load  = 1'b1;
                     cmd.st_code  = sts.chk_code;
                     cmd.fail_set = 1'b1;
                     state_in     = S_END;
                  end else if (!sts.recip_avail) begin
                     cmd.st_load  = 1'b1;
                     cmd.st_code  = STATUS_FULL;
                     cmd.fail_set = 1'b1;
                     state_in     = S_END;
                  end else begin
                     cmd.snew_load = 1'b1;
                     cmd.rd_recip  = 1'b1;
                     state_in      = S_WRS;
                  end
               end
            endcase
         end
         S_WRS: begin
            cmd.wr_send = 1'b1;
            state_in    = S_WRR;
         end
         S_WRR: begin
            cmd.wr_recip = 1'b1;
            state_in     = S_END;
         end
         S_END: begin
            if (sts.last) begin
               cmd.scan_clr = 1'b1;
               state_in     = S_SWEEP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SWEEP: begin
            cmd.scan_run = 1'b1;
            cmd.sweep    = 1'b1;
            if (sts.scan_done) begin
               cmd.blk_end = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   `ALTR_ASSERT(a_req_busy, clock, reset, (req_valid && !req_stall) |=> (state_ff != S_IDLE))
   `ALTR_ASSERT(a_sweep_resp, clock, reset, (state_ff == S_SWEEP && sts.scan_done) |=> rsp_valid)
   `ALTR_ASSERT(a_write_pair, clock, reset, (state_ff == S_WRS) |=> (state_ff == S_WRR))
   `ALTR_ASSERT(a_fail_end, clock, reset, cmd.fail_set |=> (state_ff == S_END))
   `ALTR_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_valid)
endmodule
`default_nettype wire

// ===== src/account_ledger_transfer_engine.sv =====
// From accept to response, each request searches the whole table, except a transfer of a failed
// block, which is skipped; a transfer that passes its checks also writes sender and recipient, and
// the transfer that ends a block adds a commit or rollback sweep.
// Throughput: one request in flight, the next accepted in the cycle after the response is taken;
// the key search reads one entry per cycle. Synchronous reset, then a pass clears the valid
// store while requests are stalled.
// Top level of the account ledger engine: controller plus datapath.
`default_nettype none
module account_ledger_transfer_engine import altr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [TYPE_W-1:0] req_type,
   input  wire logic [63:0]       req_account_key,
   input  wire logic [63:0]       req_recipient_key,
   input  wire logic [63:0]       req_amount,
   input  wire logic [63:0]       req_seq_number,
   input  wire logic              req_last_in_block,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [STAT_W-1:0]      rsp_status,
   output logic                   rsp_block_done,
   output logic                   rsp_block_accepted,
   output logic [63:0]            rsp_balance_out,
   output logic [63:0]            rsp_sequence_out,
   output logic                   rsp_account_found
);
   cmd_type cmd;
   sts_type sts;

   altr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   altr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_type           (req_type),
      .req_account_key    (req_account_key),
      .req_recipient_key  (req_recipient_key),
      .req_amount         (req_amount),
      .req_seq_number     (req_seq_number),
      .req_last_in_block  (req_last_in_block),
      .rsp_status         (rsp_status),
      .rsp_block_done     (rsp_block_done),
      .rsp_block_accepted (rsp_block_accepted),
      .rsp_balance_out    (rsp_balance_out),
      .rsp_sequence_out   (rsp_sequence_out),
      .rsp_account_found  (rsp_account_found)
   );
endmodule
`default_nettype wire

// ===== verif/ledger_checker.sv =====
// Checker for the ledger engine: mirrors the account tables and compares every response.
`timescale 1ns / 100ps
`default_nettype none
module ledger_checker import altr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [TYPE_W-1:0] req_type,
   input  wire logic [63:0]       req_account_key,
   input  wire logic [63:0]       req_recipient_key,
   input  wire logic [63:0]       req_amount,
   input  wire logic [63:0]       req_seq_number,
   input  wire logic              req_last_in_block,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [STAT_W-1:0] rsp_status,
   input  wire logic              rsp_block_done,
   input  wire logic              rsp_block_accepted,
   input  wire logic [63:0]       rsp_balance_out,
   input  wire logic [63:0]       rsp_sequence_out,
   input  wire logic              rsp_account_found,
   output int                     mismatches,
   output int                     outstanding
);
   localparam logic [63:0] KEY_MASK = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 1);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              done;
      logic              accepted;
      logic [63:0]       balance;
      logic [63:0]       seq_cnt;
      logic              found;
   } ledger_result_type;

   ledger_result_type expected_results[$];

   logic        com_vld  [TABLE_DEPTH];
   logic        wrk_vld  [TABLE_DEPTH];
   logic [63:0] acct_key [TABLE_DEPTH];
   logic [63:0] com_bal  [TABLE_DEPTH];
   logic [63:0] com_seq  [TABLE_DEPTH];
   logic [63:0] wrk_bal  [TABLE_DEPTH];
   logic [63:0] wrk_seq  [TABLE_DEPTH];
   logic        blk_fail;

   // Lookup in the committed copy (0), the working copy (1) or either (2).
   function automatic int find_account(logic [63:0] key, int copy_sel);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         logic v;
         v = (copy_sel == 0) ? com_vld[i] : (copy_sel == 1) ? wrk_vld[i]
                                          : (com_vld[i] | wrk_vld[i]);
         if (v && acct_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic int free_entry();
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (!com_vld[i] && !wrk_vld[i]) return i;
      return -1;
   endfunction

   function automatic logic [STAT_W-1:0] sender_status(int idx, logic [63:0] amt,
                                                        logic [63:0] sq, bit working);
      logic [63:0] bal, cnt;
      if (idx < 0) return STATUS_MISSING;
      bal = working ? wrk_bal[idx] : com_bal[idx];
      cnt = working ? wrk_seq[idx] : com_seq[idx];
      if (bal < amt) return STATUS_LOW;
      if (sq != cnt) return STATUS_SEQ;
      return STATUS_OK;
   endfunction

   function automatic ledger_result_type apply_request(logic [TYPE_W-1:0] kind,
         logic [63:0] skey, logic [63:0] rkey, logic [63:0] amt, logic [63:0] sq,
         logic last);
      ledger_result_type res;
      int e, r;
      res = '0;
      skey &= KEY_MASK;
      rkey &= KEY_MASK;
      case (kind)
         REQ_ALLOC: begin
            e = find_account(skey, 2);
            if (e < 0) e = free_entry();
            if (e < 0) res.status = STATUS_FULL;
            else begin
               acct_key[e] = skey;
               com_vld[e] = 1'b1;  wrk_vld[e] = 1'b1;
               com_bal[e] = amt;   wrk_bal[e] = amt;
               com_seq[e] = '0;    wrk_seq[e] = '0;
            end
         end
         REQ_VALIDATE: res.status = sender_status(find_account(skey, 0), amt, sq, 1'b0);
         REQ_TRANSFER: begin
            if (blk_fail) res.status = STATUS_SKIPPED;
            else begin
               e = find_account(skey, 1);
               res.status = sender_status(e, amt, sq, 1'b1);
               r = -1;
               if (res.status == STATUS_OK) begin
                  r = find_account(rkey, 1);
                  if (r < 0) begin
                     r = free_entry();
                     if (r < 0) res.status = STATUS_FULL;
                  end
               end
               if (res.status != STATUS_OK) blk_fail = 1'b1;
               else begin
                  // Debit before credit, so a transfer to oneself keeps the balance.
                  wrk_bal[e] -= amt;
                  wrk_seq[e] += 1;
                  if (!wrk_vld[r]) begin
                     acct_key[r] = rkey;
                     wrk_vld[r] = 1'b1;
                     wrk_bal[r] = '0;
                     wrk_seq[r] = '0;
                  end
                  wrk_bal[r] += amt;
               end
            end
            if (last) begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (blk_fail) begin
                     wrk_vld[i] = com_vld[i];
                     wrk_bal[i] = com_bal[i];
                     wrk_seq[i] = com_seq[i];
                  end else begin
                     com_vld[i] = wrk_vld[i];
                     com_bal[i] = wrk_bal[i];
                     com_seq[i] = wrk_seq[i];
                  end
               end
               res.done = 1'b1;
               res.accepted = !blk_fail;
               blk_fail = 1'b0;
            end
         end
         default: begin
            e = find_account(skey, 0);
            if (e >= 0) begin
               res.balance = com_bal[e];
               res.seq_cnt = com_seq[e];
               res.found = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   assign outstanding = expected_results.size();

   always @(posedge clock) begin
      ledger_result_type want, got;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            com_vld[i] = 1'b0;
            wrk_vld[i] = 1'b0;
         end
         blk_fail = 1'b0;
         expected_results.delete();
         mismatches <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(apply_request(req_type, req_account_key,
               req_recipient_key, req_amount, req_seq_number, req_last_in_block));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_block_done, rsp_block_accepted, rsp_balance_out,
                    rsp_sequence_out, rsp_account_found};
            if (expected_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response with no request waiting: %p", $realtime, got);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  if (mismatches < 10)
                     $display("%0t: response mismatch\n  expected %p\n  actual   %p",
                              $realtime, want, got);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Top of the ledger engine testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import altr_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int NUM_KEYS   = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [TYPE_W-1:0] req_type = REQ_QUERY;
   logic [63:0]       req_account_key = '0;
   logic [63:0]       req_recipient_key = '0;
   logic [63:0]       req_amount = '0;
   logic [63:0]       req_seq_number = '0;
   logic              req_last_in_block = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic [STAT_W-1:0] rsp_status;
   logic              rsp_block_done;
   logic              rsp_block_accepted;
   logic [63:0]       rsp_balance_out;
   logic [63:0]       rsp_sequence_out;
   logic              rsp_account_found;
   int                mismatches;
   int                outstanding;

   bit          no_idle = 1'b0;
   bit          hold_request = 1'b0;
   int          idle_cycles = 0;
   logic [63:0] key_pool [NUM_KEYS];
   logic [63:0] seq_guess [NUM_KEYS];

   always #10 clock = ~clock;

   account_ledger_transfer_engine dut (.*);

   ledger_checker checker_i (.*);

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_amount();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return rand64();
      if (pick == 1) return '1;
      return 64'($urandom_range(0, 1000));
   endfunction

   task automatic send_request(logic [TYPE_W-1:0] kind, logic [63:0] skey,
         logic [63:0] rkey, logic [63:0] amt, logic [63:0] sq, logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type <= kind;
      req_account_key <= skey;
      req_recipient_key <= rkey;
      req_amount <= amt;
      req_seq_number <= sq;
      req_last_in_block <= last;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Receiver: random stall before each response, with one long hold-off on request.
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (1000) @(posedge clock);
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      logic [63:0] ka, kb, kc, kd, kmax;
      int s, r, nblk, pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      ka = 64'h0123_4567_89AB_CDEF; kb = '0; kc = 64'hFEDC_BA98_7654_3210;
      kd = 64'h5555_AAAA_5555_AAAA; kmax = '1;
      send_request(REQ_ALLOC, ka, '0, '1, '0, 1'b1);      // last ignored on allocate
      send_request(REQ_ALLOC, kb, '0, '0, '0, 1'b0);
      send_request(REQ_ALLOC, kmax, '0, 64'd100, '0, 1'b0);
      send_request(REQ_QUERY, ka, '0, '0, '0, 1'b0);
      send_request(REQ_QUERY, kc, '0, '0, '0, 1'b0);      // missing account
      send_request(REQ_VALIDATE, kc, '0, 64'd1, '0, 1'b0);
      send_request(REQ_VALIDATE, kb, '0, 64'd1, '0, 1'b0);
      send_request(REQ_VALIDATE, ka, '0, 64'd5, '1, 1'b0);
      send_request(REQ_VALIDATE, ka, '0, '1, '0, 1'b0);
      send_request(REQ_TRANSFER, ka, kb, 64'd1000, '0, 1'b0);
      send_request(REQ_TRANSFER, ka, ka, 64'd7, 64'd1, 1'b0);   // self transfer
      send_request(REQ_TRANSFER, ka, kc, '0, 64'd2, 1'b1);      // creates recipient
      send_request(REQ_QUERY, kc, '0, '0, '0, 1'b0);
      send_request(REQ_ALLOC, kd, '0, '1, '0, 1'b0);
      send_request(REQ_TRANSFER, ka, kd, 64'd10, 64'd3, 1'b1);  // credit wraps
      send_request(REQ_TRANSFER, ka, kb, 64'd1, 64'd9, 1'b0);   // wrong sequence
      send_request(REQ_TRANSFER, ka, kb, 64'd1, 64'd4, 1'b0);   // skipped
      send_request(REQ_TRANSFER, kc, kb, 64'd1, '0, 1'b1);      // rolled back
      send_request(REQ_TRANSFER, kb, kc, '1, '0, 1'b1);         // failing single block
      send_request(REQ_QUERY, ka, '0, '0, '0, 1'b0);
      send_request(REQ_QUERY, kd, '0, '0, '0, 1'b0);
      send_request(REQ_QUERY, kmax, '0, '0, '0, 1'b0);
      wait_drained();

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < NUM_KEYS; i++) key_pool[i] = rand64();
      for (int i = 0; i < NUM_KEYS; i++) begin
         send_request(REQ_ALLOC, key_pool[i], '0, 64'($urandom_range(1 << 16, 1 << 24)),
                      '0, 1'b0);
         seq_guess[i] = '0;
      end

      // Random part; most traffic is transfer blocks with plausible sequence counts.
      for (int n = 0; n < 560; n++) begin
         if (n == 150) no_idle = 1'b1;
         if (n == 230) no_idle = 1'b0;
         if (n == 300) hold_request = 1'b1;
         if (n == 400) wait_drained();
         s = $urandom_range(0, NUM_KEYS - 1);
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            send_request(REQ_ALLOC, ($urandom_range(0, 9) == 0) ? rand64() : key_pool[s],
                         rand64(), ($urandom_range(0, 3) == 0) ? rand64()
                         : 64'($urandom_range(0, 1 << 20)), rand64(), 1'($urandom));
            seq_guess[s] = '0;
         end else if (pick < 5) begin
            send_request(REQ_VALIDATE, key_pool[s], rand64(), rand_amount(),
                         ($urandom_range(0, 2) == 0) ? rand64() : seq_guess[s],
                         1'($urandom));
         end else if (pick < 8) begin
            send_request(REQ_QUERY, ($urandom_range(0, 9) == 0) ? rand64() : key_pool[s],
                         rand64(), rand64(), rand64(), 1'($urandom));
         end else begin
            nblk = $urandom_range(1, 5);
            for (int t = 0; t < nblk; t++) begin
               s = $urandom_range(0, NUM_KEYS - 1);
               r = $urandom_range(0, NUM_KEYS - 1);
               send_request(REQ_TRANSFER,
                  ($urandom_range(0, 19) == 0) ? rand64() : key_pool[s],
                  ($urandom_range(0, 14) == 0) ? rand64() : key_pool[r], rand_amount(),
                  ($urandom_range(0, 9) == 0) ? rand64() : seq_guess[s],
                  t == nblk - 1);
               seq_guess[s] += 1;
            end
            n += nblk - 1;
         end
      end

      // Fill the table, then hit the full case on allocate and on transfer.
      for (int i = 0; i < 270; i++)
         send_request(REQ_ALLOC, {32'hA5A5_0000 + 32'(i), $urandom}, rand64(),
                      rand_amount(), rand64(), 1'b0);
      for (int i = 0; i < 6; i++) begin
         s = $urandom_range(0, NUM_KEYS - 1);
         send_request(REQ_TRANSFER, key_pool[s], rand64(), 64'd0, seq_guess[s], 1'b1);
         send_request(REQ_TRANSFER, key_pool[s], key_pool[0], 64'd0, seq_guess[s], 1'b1);
         seq_guess[s] += 1;
         send_request(REQ_QUERY, key_pool[s], '0, '0, '0, 1'b0);
      end

      wait_drained();
      repeat (600) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/altr_pkg.sv
src/altr_ram.sv
src/altr_dp.sv
src/altr_ctrl.sv
src/account_ledger_transfer_engine.sv
verif/ledger_checker.sv
verif/tb_top.sv
